[rtl/core/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/srtf_pkg.sv]
// Shared constants and types of the SRTF scheduler.
// Depends on nothing; imported by every scheduler module.
`timescale 1ns / 1ps

package srtf_pkg;

   localparam int MAX_PROCS  = 16;
   localparam int SLOT_W     = $clog2(MAX_PROCS);
   localparam int TIME_W     = 16;
   localparam int PID_W      = 6;
   localparam int BURST_W    = 12;
   localparam int RPT_W      = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PROCS - 1);

   // Transaction kind carried on req_tuser
   localparam logic MODE_ADMIT = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // One slot of the process table as seen on the read port
   typedef struct packed {
      logic               valid;
      logic [PID_W-1:0]   pid;
      logic [BURST_W-1:0] remaining;
      logic [BURST_W-1:0] total;
      logic [TIME_W-1:0]  arrival;
   } slot_entry_type;

   // Table update command from the sequencer
   typedef struct packed {
      logic              admit;
      logic              retire;
      logic              decr;
      logic [SLOT_W-1:0] slot;
   } tbl_cmd_type;

   // Priority key of one process
   typedef struct packed {
      logic [BURST_W-1:0] remaining;
      logic [TIME_W-1:0]  age;
      logic [PID_W-1:0]   pid;
   } prio_key_type;

endpackage

[rtl/core/srtf_scheduler.sv]
// SRTF scheduler top level: sequencer, best-slot registers and result register.
// Admit: accepted while idle, no result. Tick: a scan of every slot (one slot per cycle
// through the shared comparator), then an update state and a result state that loads
// rsp_tvalid; no new request is taken until that result is loaded. Synchronous
// active-high reset clears all valid marks, time and the overflow flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srtf_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [5:0] proc_id, [17:6] burst_len, [23:18] zero
   input  logic [srtf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] mode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] busy_res, [6:1] run_id, [7] finished, [23:8] turnaround,
   // [39:24] waiting, [40] table_overflow, [47:41] zero
   output logic [srtf_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import srtf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic               ovf_ff, ovf_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  best_slot_ff, best_slot_in;
   prio_key_type       best_key_ff, best_key_in;
   logic [BURST_W-1:0] best_total_ff, best_total_in;
   logic               done_ff, done_in;
   logic [TIME_W-1:0]  turn_ff, turn_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_busy_ff, rsp_busy_in;
   logic [PID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic               rsp_fin_ff, rsp_fin_in;
   logic [RPT_W-1:0]   rsp_turn_ff, rsp_turn_in;
   logic [RPT_W-1:0]   rsp_wait_ff, rsp_wait_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               req_mode;
   logic [PID_W-1:0]   req_pid;
   logic [BURST_W-1:0] req_burst;
   logic               req_fire;

   tbl_cmd_type        cmd;
   slot_entry_type     rd_entry;
   logic [SLOT_W-1:0]  free_slot;
   logic               full;
   prio_key_type       cand_key;
   logic               take;
   logic [TIME_W-1:0]  wait_calc;

   // Unpack the request transaction
   assign req_mode  = req_tuser;
   assign req_pid   = req_tdata[PID_W-1:0];
   assign req_burst = req_tdata[PID_W+BURST_W-1:PID_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   srtf_table u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_pid     (req_pid),
      .wr_burst   (req_burst),
      .wr_arrival (time_ff),
      .rd_slot    (idx_ff),
      .rd_entry   (rd_entry),
      .free_slot  (free_slot),
      .full       (full)
   );

   // Key of the slot under scan
   assign cand_key.remaining = rd_entry.remaining;
   assign cand_key.age       = time_ff - rd_entry.arrival;
   assign cand_key.pid       = rd_entry.pid;

   srtf_cmp u_cmp (
      .cand       (cand_key),
      .best       (best_key_ff),
      .best_found (found_ff),
      .take       (take)
   );

   assign wait_calc = turn_ff - TIME_W'(best_total_ff);

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      ovf_in        = ovf_ff;
      found_in      = found_ff;
      best_slot_in  = best_slot_ff;
      best_key_in   = best_key_ff;
      best_total_in = best_total_ff;
      done_in       = done_ff;
      turn_in       = turn_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_busy_in   = rsp_busy_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_turn_in   = rsp_turn_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      cmd           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_TICK) begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (req_burst != '0) begin
                  // Admit into the lowest free slot or flag the drop
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     cmd.admit = 1'b1;
                     cmd.slot  = free_slot;
                  end
               end
            end
         end
         ST_SCAN: begin
            // One slot per cycle through the shared comparator
            if (rd_entry.valid && take) begin
               found_in      = 1'b1;
               best_slot_in  = idx_ff;
               best_key_in   = cand_key;
               best_total_in = rd_entry.total;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_FINISH: begin
            // Advance time, then retire or decrement the winner
            time_in  = time_ff + TIME_W'(1);
            done_in  = 1'b0;
            turn_in  = best_key_ff.age + TIME_W'(1);
            cmd.slot = best_slot_ff;
            if (found_ff) begin
               if (best_key_ff.remaining <= BURST_W'(1)) begin
                  done_in    = 1'b1;
                  cmd.retire = 1'b1;
               end else begin
                  cmd.decr = 1'b1;
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Load the result register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_busy_in  = found_ff;
               rsp_id_in    = found_ff ? best_key_ff.pid : '0;
               rsp_fin_in   = done_ff;
               rsp_turn_in  = done_ff ? RPT_W'(turn_ff) : '0;
               rsp_wait_in  = done_ff ? RPT_W'(wait_calc) : '0;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         time_ff      <= '0;
         ovf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         time_ff      <= time_in;
         ovf_ff       <= ovf_in;
         found_ff     <= found_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      best_slot_ff  <= best_slot_in;
      best_key_ff   <= best_key_in;
      best_total_ff <= best_total_in;
      turn_ff       <= turn_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_turn_ff   <= rsp_turn_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // Pack the response transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ovf_ff, rsp_wait_ff, rsp_turn_ff,
                        rsp_fin_ff, rsp_id_ff, rsp_busy_ff};

   // A tick transaction always starts a scan at slot zero
   `ASSERT_NEXT(a_tick_starts_scan, clock, reset, req_fire && (req_mode == MODE_TICK), (state_ff == ST_SCAN) && (idx_ff == '0))
   // The scan index steps by one each cycle until the last slot
   `ASSERT_NEXT(a_scan_steps, clock, reset, (state_ff == ST_SCAN) && (idx_ff != LAST_SLOT), idx_ff == $past(idx_ff) + SLOT_W'(1))
   // A completion is only reported for a process that ran
   `ASSERT_IMPL(a_fin_needs_busy, clock, reset, rsp_valid_ff && rsp_fin_ff, rsp_busy_ff)

endmodule

[rtl/core/srtf_cmp.sv]
// Shared priority comparator: decides whether a candidate slot beats the best so far.
// Depends on srtf_pkg.
`timescale 1ns / 1ps

module srtf_cmp (
   input  srtf_pkg::prio_key_type cand,
   input  srtf_pkg::prio_key_type best,
   input  logic                   best_found,
   output logic                   take
);
   import srtf_pkg::*;

   // Less remaining wins, then older arrival, then lower id; full ties keep the earlier slot
   always_comb begin
      if (!best_found) begin
         take = 1'b1;
      end else if (cand.remaining != best.remaining) begin
         take = cand.remaining < best.remaining;
      end else if (cand.age != best.age) begin
         take = cand.age > best.age;
      end else begin
         take = cand.pid < best.pid;
      end
   end

endmodule

[rtl/core/srtf_table.sv]
// Process slot table: valid bits, per-slot fields, one read port and free-slot search.
// Depends on srtf_pkg.
`timescale 1ns / 1ps

module srtf_table (
   input  logic                         clock,
   input  logic                         reset,
   input  srtf_pkg::tbl_cmd_type        cmd,
   input  logic [srtf_pkg::PID_W-1:0]   wr_pid,
   input  logic [srtf_pkg::BURST_W-1:0] wr_burst,
   input  logic [srtf_pkg::TIME_W-1:0]  wr_arrival,
   input  logic [srtf_pkg::SLOT_W-1:0]  rd_slot,
   output srtf_pkg::slot_entry_type     rd_entry,
   output logic [srtf_pkg::SLOT_W-1:0]  free_slot,
   output logic                         full
);
   import srtf_pkg::*;

   logic [MAX_PROCS-1:0] valid_ff;
   logic [PID_W-1:0]     pid_ff       [MAX_PROCS];
   logic [BURST_W-1:0]   remaining_ff [MAX_PROCS];
   logic [BURST_W-1:0]   total_ff     [MAX_PROCS];
   logic [TIME_W-1:0]    arrival_ff   [MAX_PROCS];

   // Find the lowest free slot
   always_comb begin
      free_slot = '0;
      full      = 1'b1;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
            full      = 1'b0;
         end
      end
   end

   // Read the slot under scan
   always_comb begin
      rd_entry.valid     = valid_ff[rd_slot];
      rd_entry.pid       = pid_ff[rd_slot];
      rd_entry.remaining = remaining_ff[rd_slot];
      rd_entry.total     = total_ff[rd_slot];
      rd_entry.arrival   = arrival_ff[rd_slot];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.admit) begin
         valid_ff[cmd.slot] <= 1'b1;
      end else if (cmd.retire) begin
         valid_ff[cmd.slot] <= 1'b0;
      end
   end

   // Slot payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.admit) begin
         pid_ff[cmd.slot]       <= wr_pid;
         remaining_ff[cmd.slot] <= wr_burst;
         total_ff[cmd.slot]     <= wr_burst;
         arrival_ff[cmd.slot]   <= wr_arrival;
      end else if (cmd.decr) begin
         remaining_ff[cmd.slot] <= remaining_ff[cmd.slot] - BURST_W'(1);
      end
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for srtf_scheduler: sends admit and tick transactions,
// predicts every tick report from its own copy of the process table, checks each field.
// Depends on srtf_pkg and the srtf_scheduler RTL.

module testbench;
   import srtf_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_CYCLES = 40;

   // One tick report, busy_res in the lowest bit as on rsp_tdata
   typedef struct packed {
      logic               overflow;
      logic [RPT_W-1:0]   waiting;
      logic [RPT_W-1:0]   turnaround;
      logic               finished;
      logic [PID_W-1:0]   run_id;
      logic               busy;
   } tick_report_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [5:0] proc_id, [17:6] burst_len, [23:18] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [0] mode
   logic                  req_tuser  = MODE_ADMIT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] busy_res, [6:1] run_id, [7] finished, [23:8] turnaround,
   // [39:24] waiting, [40] table_overflow, [47:41] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predicted process table and scheduler state
   logic               proc_used  [MAX_PROCS];
   logic [PID_W-1:0]   proc_pid   [MAX_PROCS];
   logic [BURST_W-1:0] proc_left  [MAX_PROCS];
   logic [BURST_W-1:0] proc_burst [MAX_PROCS];
   logic [TIME_W-1:0]  proc_stamp [MAX_PROCS];
   logic [TIME_W-1:0]  sched_time;
   logic               overflow_seen;
   tick_report_type    expected_reports[$];

   // Run bookkeeping
   int  error_count   = 0;
   int  items_sent    = 0;
   int  tick_count    = 0;
   int  idle_ticks    = 0;
   int  completions   = 0;
   int  dropped_admits = 0;
   int  quiet_cycles  = 0;
   int  stall_left    = 0;
   bit  no_idle       = 1'b0;

   srtf_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial forever #5 clock = ~clock;

   // Gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Burst length for well-formed batches: mostly tiny, sometimes longer
   function automatic logic [BURST_W-1:0] pick_burst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return BURST_W'($urandom_range(1, 4));
      if (r < 98) return BURST_W'($urandom_range(5, 24));
      return BURST_W'($urandom_range(25, 200));
   endfunction

   function automatic int free_slots();
      int n;
      n = 0;
      for (int i = 0; i < MAX_PROCS; i++)
         if (!proc_used[i]) n++;
      return n;
   endfunction

   // Priority: least remaining, then oldest, then lower id, then lower slot
   function automatic bit runs_before(int a, int b);
      logic [TIME_W-1:0] age_a;
      logic [TIME_W-1:0] age_b;
      if (proc_left[a] != proc_left[b]) return proc_left[a] < proc_left[b];
      age_a = sched_time - proc_stamp[a];
      age_b = sched_time - proc_stamp[b];
      if (age_a != age_b) return age_a > age_b;
      if (proc_pid[a] != proc_pid[b]) return proc_pid[a] < proc_pid[b];
      return a < b;
   endfunction

   // Apply one accepted transaction to the predicted table; queue a report per tick
   task automatic predict_schedule(input logic mode, input logic [PID_W-1:0] pid,
                                   input logic [BURST_W-1:0] burst);
      int                best;
      int                slot;
      logic [TIME_W-1:0] span;
      tick_report_type   rpt;
      if (mode == MODE_ADMIT) begin
         if (burst == '0) return;
         slot = -1;
         for (int i = 0; i < MAX_PROCS; i++)
            if (!proc_used[i] && slot < 0) slot = i;
         if (slot < 0) begin
            overflow_seen = 1'b1;
            dropped_admits++;
         end else begin
            proc_used[slot]  = 1'b1;
            proc_pid[slot]   = pid;
            proc_left[slot]  = burst;
            proc_burst[slot] = burst;
            proc_stamp[slot] = sched_time;
         end
         return;
      end
      best = -1;
      for (int i = 0; i < MAX_PROCS; i++)
         if (proc_used[i] && (best < 0 || runs_before(i, best))) best = i;
      sched_time = sched_time + TIME_W'(1);
      rpt = '0;
      if (best >= 0) begin
         rpt.busy   = 1'b1;
         rpt.run_id = proc_pid[best];
         if (proc_left[best] <= BURST_W'(1)) begin
            span             = sched_time - proc_stamp[best];
            rpt.finished     = 1'b1;
            rpt.turnaround   = RPT_W'(span);
            rpt.waiting      = RPT_W'(TIME_W'(span - TIME_W'(proc_burst[best])));
            proc_used[best]  = 1'b0;
            completions++;
         end else begin
            proc_left[best] = proc_left[best] - BURST_W'(1);
         end
      end else begin
         idle_ticks++;
      end
      rpt.overflow = overflow_seen;
      expected_reports = {expected_reports, rpt};
      tick_count++;
   endtask

   // Send one transaction after a random gap; keep valid high into the next one
   task automatic send_item(input logic mode, input logic [PID_W-1:0] pid,
                            input logic [BURST_W-1:0] burst);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_W'({burst, pid});
      do @(posedge clock); while (!req_tready);
      predict_schedule(mode, pid, burst);
      items_sent++;
   endtask

   // Ticks carry random, ignored id and burst bits
   task automatic send_ticks(input int n);
      repeat (n) send_item(MODE_TICK, PID_W'($urandom), BURST_W'($urandom));
   endtask

   task automatic check_field(input string name, input logic [RPT_W-1:0] want,
                              input logic [RPT_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Check each report transaction and drive rsp_tready with random stalls
   always @(posedge clock) begin
      tick_report_type got;
      tick_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(tick_report_type)-1:0];
            if (expected_reports.size() == 0) begin
               error_count++;
               $display("%0t: report with nothing expected, expected none, actual %h",
                        $time, got);
            end else begin
               want = expected_reports.pop_front();
               check_field("busy_res", RPT_W'(want.busy), RPT_W'(got.busy));
               check_field("run_id", RPT_W'(want.run_id), RPT_W'(got.run_id));
               check_field("finished", RPT_W'(want.finished), RPT_W'(got.finished));
               check_field("turnaround", want.turnaround, got.turnaround);
               check_field("waiting", want.waiting, got.waiting);
               check_field("table_overflow", RPT_W'(want.overflow), RPT_W'(got.overflow));
            end
         end
         if (no_idle) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Idle ticks, zero burst, extreme ids and the longest burst
   task automatic test_idle_and_zero_burst();
      send_ticks(1);
      send_item(MODE_ADMIT, 6'd0, 12'd0);
      send_ticks(1);
      send_item(MODE_ADMIT, 6'd63, 12'd4095);
      send_item(MODE_ADMIT, 6'd5, 12'd1);
      send_ticks(1);
   endtask

   // Ties on remaining time: lower id, duplicate ids, older arrival over lower id
   task automatic test_tie_breaks();
      send_item(MODE_ADMIT, 6'd9, 12'd2);
      send_item(MODE_ADMIT, 6'd3, 12'd2);
      send_ticks(4);
      send_item(MODE_ADMIT, 6'd7, 12'd1);
      send_item(MODE_ADMIT, 6'd7, 12'd1);
      send_ticks(2);
      send_item(MODE_ADMIT, 6'd30, 12'd2);
      send_ticks(1);
      send_item(MODE_ADMIT, 6'd10, 12'd1);
      send_ticks(2);
   endtask

   // Fill every free slot, then one more admit that must be dropped
   task automatic test_table_full();
      int                 fill;
      int                 work;
      logic [BURST_W-1:0] b;
      fill = free_slots();
      work = 0;
      repeat (fill + 1) begin
         b = BURST_W'($urandom_range(1, 3));
         work += b;
         send_item(MODE_ADMIT, PID_W'($urandom), b);
      end
      send_item(MODE_ADMIT, PID_W'($urandom), 12'd0);
      send_ticks(work);
   endtask

   // Batches of admits followed by enough ticks to work them off, plus noise
   task automatic test_random();
      int                 r;
      int                 k;
      int                 work;
      int                 start_count;
      logic [BURST_W-1:0] b;
      logic [PID_W-1:0]   pid;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(MODE_ADMIT, PID_W'($urandom), 12'd0);
         end else if (r < 7) begin
            send_item(MODE_ADMIT, PID_W'($urandom), BURST_W'($urandom_range(1, 4095)));
         end else if (r < 12) begin
            send_ticks($urandom_range(1, 3));
         end else begin
            k = $urandom_range(1, 6);
            work = 0;
            repeat (k) begin
               b = pick_burst();
               work += b;
               // a small id pool makes equal-id ties common
               pid = ($urandom_range(0, 3) == 0) ? PID_W'($urandom_range(0, 3))
                                                 : PID_W'($urandom);
               send_item(MODE_ADMIT, pid, b);
            end
            send_ticks($urandom_range(work / 2, work + 2));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         proc_used[i]  = 1'b0;
         proc_pid[i]   = '0;
         proc_left[i]  = '0;
         proc_burst[i] = '0;
         proc_stamp[i] = '0;
      end
      sched_time    = '0;
      overflow_seen = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_zero_burst();
      test_tie_breaks();
      test_table_full();
      test_random();

      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions: %0d ticks (%0d idle), %0d completions,",
               items_sent, tick_count, idle_ticks, completions);
      $display("%0d admits dropped on a full table, mismatches: %0d",
               dropped_admits, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
